### rtl/truss_element_stiffness_triplets_core_defines.svh
// Assertion macros for the truss stiffness triplet core.
// Depends on nothing; the user scope must provide clk and rst_n.
`ifndef TRUSS_ELEMENT_STIFFNESS_TRIPLETS_CORE_DEFINES_SVH
`define TRUSS_ELEMENT_STIFFNESS_TRIPLETS_CORE_DEFINES_SVH

// Condition holds at every edge out of reset.
`define TRST_ASSERT_HOLDS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("trst: property failed");

// Consequent holds in the same cycle as the antecedent.
`define TRST_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trst: implication failed");

// Consequent holds in the cycle after the antecedent.
`define TRST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trst: next-cycle implication failed");

`endif

### rtl/trst_pkg.sv
// Shared types, constants and tables for the truss stiffness triplet core.
// No dependencies.
package trst_pkg;

    localparam int MAX_NODES = 65536;
    localparam int RANGE_W   = 25;     // holds the node limit up to 2^24
    localparam int NODE_W    = 16;
    localparam int COORD_W   = 32;
    localparam int CFG_W     = 32;
    localparam int IDX_W     = 18;
    localparam int VAL_W     = 48;
    localparam int COS_W     = 31;     // Q1.30 cosine magnitude
    localparam int PROD_W    = 32;     // rounded cosine product, Q.30
    localparam int MAG_W     = 34;     // entry magnitude, Q.16; never reaches the 47-bit limit
    localparam int N_AXIS    = 3;
    localparam int N_ENTRY   = 9;
    localparam int N_PROD    = 6;

    typedef enum logic [0:0] {
        CFG_AXIAL_STIFFNESS = 1'b0,
        CFG_INVERSE_LENGTH  = 1'b1
    } cfg_index_t;

    typedef logic [1:0] axis_t;
    typedef logic [2:0] prod_t;
    typedef logic [3:0] entry_t;

    typedef struct packed {
        logic        [NODE_W-1:0]  start_node;
        logic        [NODE_W-1:0]  end_node;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_z;
    } item_t;

    typedef struct packed {
        logic        [IDX_W-1:0] row_index;
        logic        [IDX_W-1:0] column_index;
        logic signed [VAL_W-1:0] stiffness_value;
        logic                    last;
    } result_t;

    // One classified element as handed from front to back.
    typedef struct packed {
        logic [IDX_W-1:0]                 base0;   // 3 * start_node
        logic [IDX_W-1:0]                 base1;   // 3 * end_node
        logic [N_AXIS-1:0]                neg;     // cosine sign per axis
        logic [N_ENTRY-1:0]               mask;    // nonzero entries of one node pair
        logic [N_PROD-1:0][MAG_W-1:0]     mag;     // xx, yy, zz, xy, xz, yz
    } elem_t;

    typedef struct packed {
        logic   found;
        entry_t idx;
    } pick_t;

    // Entry order within a node pair: xx, yx, xy, zx, xz, yy, yz, zy, zz.
    localparam axis_t AXIS_ROW [N_ENTRY] = '{2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
    localparam axis_t AXIS_COL [N_ENTRY] = '{2'd0, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd2, 2'd1, 2'd2};
    localparam prod_t PROD_SEL [N_ENTRY] = '{3'd0, 3'd3, 3'd3, 3'd4, 3'd4, 3'd1, 3'd5, 3'd5, 3'd2};

    // Operand axes of each distinct product.
    localparam axis_t PROD_A [N_PROD] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1};
    localparam axis_t PROD_B [N_PROD] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

    // Lowest set mask bit at or above lo.
    function automatic pick_t first_from(input logic [N_ENTRY-1:0] mask, input entry_t lo);
        pick_t pick;
        pick = '0;
        for (int n = N_ENTRY - 1; n >= 0; n--)
        begin
            if (mask[n] && (entry_t'(n) >= lo))
            begin
                pick.found = 1'b1;
                pick.idx   = entry_t'(n);
            end
        end
        return pick;
    endfunction

endpackage

### rtl/trst_front.sv
// Front end: accepts elements, forms cosines and entry magnitudes in four stages,
// drops empty or out-of-range elements. Depends on trst_pkg.
module trst_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  trst_pkg::item_t            item,
    input  logic [trst_pkg::CFG_W-1:0] axial_stiffness,
    input  logic [trst_pkg::CFG_W-1:0] inverse_length,
    output logic                       q_push,
    output trst_pkg::elem_t            q_word,
    input  logic                       q_ready
);
    import trst_pkg::*;

    logic adv1, adv2, adv3, adv4, need4;

    // stage 1: differences
    logic                                v1_reg, v1_next;
    logic [IDX_W-1:0]                    base0_1_reg, base1_1_reg;
    logic [N_AXIS-1:0]                   neg1_reg;
    logic                                keep1_reg;
    logic [N_AXIS-1:0][COORD_W-1:0]      dm1_reg;
    // stage 2: cosines
    logic                                v2_reg;
    logic [IDX_W-1:0]                    base0_2_reg, base1_2_reg;
    logic [N_AXIS-1:0]                   neg2_reg;
    logic                                keep2_reg;
    logic [N_AXIS-1:0][COS_W-1:0]        cos2_reg;
    // stage 3: cosine products
    logic                                v3_reg;
    logic [IDX_W-1:0]                    base0_3_reg, base1_3_reg;
    logic [N_AXIS-1:0]                   neg3_reg;
    logic                                keep3_reg;
    logic [N_PROD-1:0][PROD_W-1:0]       p3_reg;
    // stage 4: entry magnitudes
    logic                                v4_reg;
    logic [IDX_W-1:0]                    base0_4_reg, base1_4_reg;
    logic [N_AXIS-1:0]                   neg4_reg;
    logic                                keep4_reg;
    logic [N_PROD-1:0][MAG_W-1:0]        mag4_reg;

    logic signed [COORD_W-1:0]           s_c [N_AXIS];
    logic signed [COORD_W-1:0]           e_c [N_AXIS];
    logic [N_AXIS-1:0][COORD_W-1:0]      dm1_next;
    logic [N_AXIS-1:0]                   neg1_next;
    logic                                keep1_next;
    logic [N_AXIS-1:0][COS_W-1:0]        cos2_next;
    logic [N_PROD-1:0][PROD_W-1:0]       p3_next;
    logic [N_PROD-1:0][MAG_W-1:0]        mag4_next;
    logic [N_ENTRY-1:0]                  mask4;

    assign adv4 = !v4_reg || !need4 || q_ready;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign full = !adv1;
    assign v1_next = push;

    always_comb
    begin
        logic signed [COORD_W:0] d;
        s_c[0] = item.start_x;
        s_c[1] = item.start_y;
        s_c[2] = item.start_z;
        e_c[0] = item.end_x;
        e_c[1] = item.end_y;
        e_c[2] = item.end_z;
        for (int a = 0; a < N_AXIS; a++)
        begin
            d = {e_c[a][COORD_W-1], e_c[a]} - {s_c[a][COORD_W-1], s_c[a]};
            neg1_next[a] = d[COORD_W];
            dm1_next[a]  = COORD_W'(d[COORD_W] ? ((COORD_W+1)'(0) - d) : d);
        end
        keep1_next = ({{(RANGE_W-NODE_W){1'b0}}, item.start_node} < RANGE_W'(MAX_NODES))
                  && ({{(RANGE_W-NODE_W){1'b0}}, item.end_node} < RANGE_W'(MAX_NODES));
    end

    // cosine: round Q.32 to Q1.30, halves away from zero, saturate magnitude
    always_comb
    begin
        logic [2*COORD_W-1:0] m;
        logic [2*COORD_W:0]   s;
        for (int a = 0; a < N_AXIS; a++)
        begin
            m = dm1_reg[a] * inverse_length;
            s = {1'b0, m} + (2*COORD_W+1)'(2);
            if (s[2*COORD_W:COS_W+2] != '0)
                cos2_next[a] = {COS_W{1'b1}};
            else
                cos2_next[a] = s[COS_W+1:2];
        end
    end

    always_comb
    begin
        logic [2*COS_W-1:0] pr;
        logic [2*COS_W:0]   s;
        for (int p = 0; p < N_PROD; p++)
        begin
            pr = cos2_reg[PROD_A[p]] * cos2_reg[PROD_B[p]];
            s  = {1'b0, pr} + (2*COS_W+1)'(64'd1 << 29);
            p3_next[p] = s[PROD_W+29:30];
        end
    end

    always_comb
    begin
        logic [PROD_W+CFG_W-1:0] q;
        logic [PROD_W+CFG_W:0]   s;
        for (int p = 0; p < N_PROD; p++)
        begin
            q = p3_reg[p] * axial_stiffness;
            s = {1'b0, q} + (PROD_W+CFG_W+1)'(64'd1 << 29);
            mag4_next[p] = s[MAG_W+29:30];
        end
    end

    always_comb
    begin
        for (int k = 0; k < N_ENTRY; k++)
            mask4[k] = mag4_reg[PROD_SEL[k]] != '0;
    end

    assign need4  = keep4_reg && (mask4 != '0);
    assign q_push = v4_reg && need4 && q_ready;

    always_comb
    begin
        q_word.base0 = base0_4_reg;
        q_word.base1 = base1_4_reg;
        q_word.neg   = neg4_reg;
        q_word.mask  = mask4;
        q_word.mag   = mag4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= v1_next;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            base0_1_reg <= {1'b0, item.start_node, 1'b0} + {2'b00, item.start_node};
            base1_1_reg <= {1'b0, item.end_node, 1'b0} + {2'b00, item.end_node};
            neg1_reg    <= neg1_next;
            keep1_reg   <= keep1_next;
            dm1_reg     <= dm1_next;
        end
        if (adv2)
        begin
            base0_2_reg <= base0_1_reg;
            base1_2_reg <= base1_1_reg;
            neg2_reg    <= neg1_reg;
            keep2_reg   <= keep1_reg;
            cos2_reg    <= cos2_next;
        end
        if (adv3)
        begin
            base0_3_reg <= base0_2_reg;
            base1_3_reg <= base1_2_reg;
            neg3_reg    <= neg2_reg;
            keep3_reg   <= keep2_reg;
            p3_reg      <= p3_next;
        end
        if (adv4)
        begin
            base0_4_reg <= base0_3_reg;
            base1_4_reg <= base1_3_reg;
            neg4_reg    <= neg3_reg;
            keep4_reg   <= keep3_reg;
            mag4_reg    <= mag4_next;
        end
    end

endmodule

### rtl/trst_elem_queue.sv
// Two-entry queue of classified elements between front and back.
// Depends on trst_pkg.
module trst_elem_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  trst_pkg::elem_t wr_word,
    output logic            not_full,
    input  logic            rd_en,
    output trst_pkg::elem_t rd_word,
    output logic            not_empty
);
    import trst_pkg::*;

    elem_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign not_full  = count_reg != 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign rd_word   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_word;
    end

endmodule

### rtl/trst_back.sv
// Back end: walks the nonzero entries of each element over the four node pairs,
// one triplet per cycle while its two-word result queue has room. Depends on trst_pkg.
module trst_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  trst_pkg::elem_t   q_word,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output trst_pkg::result_t result
);
    import trst_pkg::*;

    elem_t      cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [1:0] pair_reg, pair_next;
    entry_t     k_reg, k_next;

    result_t    ofifo_reg [2];
    logic       owr_ptr_reg, ord_ptr_reg;
    logic [1:0] ocnt_reg;

    pick_t      nxt, restart, first_new;
    logic       final_entry, emit, load, do_pop;
    logic       i_sel, j_sel, neg;
    logic [MAG_W-1:0] mag;
    result_t    trip;

    assign nxt         = first_from(cur_reg.mask, k_reg + entry_t'(1));
    assign restart     = first_from(cur_reg.mask, entry_t'(0));
    assign first_new   = first_from(q_word.mask, entry_t'(0));
    assign final_entry = (pair_reg == 2'd3) && !nxt.found;
    assign emit        = cur_valid_reg && (ocnt_reg != 2'd2);
    // take the next element in the cycle the current one finishes
    assign load        = q_valid && (!cur_valid_reg || (emit && final_entry));
    assign q_pop       = load;
    assign do_pop      = pop && (ocnt_reg != 2'd0);

    always_comb
    begin
        i_sel = pair_reg[1];
        j_sel = pair_reg[0];
        mag   = cur_reg.mag[PROD_SEL[k_reg]];
        neg   = cur_reg.neg[AXIS_ROW[k_reg]] ^ cur_reg.neg[AXIS_COL[k_reg]] ^ i_sel ^ j_sel;
        trip.row_index    = (i_sel ? cur_reg.base1 : cur_reg.base0)
                          + {{(IDX_W-2){1'b0}}, AXIS_ROW[k_reg]};
        trip.column_index = (j_sel ? cur_reg.base1 : cur_reg.base0)
                          + {{(IDX_W-2){1'b0}}, AXIS_COL[k_reg]};
        trip.stiffness_value = neg ? (VAL_W'(0) - {{(VAL_W-MAG_W){1'b0}}, mag})
                                   : {{(VAL_W-MAG_W){1'b0}}, mag};
        trip.last = final_entry;
    end

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        pair_next      = pair_reg;
        k_next         = k_reg;
        if (load)
        begin
            cur_next       = q_word;
            cur_valid_next = 1'b1;
            pair_next      = 2'd0;
            k_next         = first_new.idx;
        end
        else if (emit)
        begin
            priority if (final_entry)
                cur_valid_next = 1'b0;
            else if (nxt.found)
                k_next = nxt.idx;
            else
            begin
                pair_next = pair_reg + 2'd1;
                k_next    = restart.idx;
            end
        end
    end

    assign empty  = ocnt_reg == 2'd0;
    assign result = ofifo_reg[ord_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pair_reg      <= 2'd0;
            k_reg         <= '0;
            owr_ptr_reg   <= 1'b0;
            ord_ptr_reg   <= 1'b0;
            ocnt_reg      <= 2'd0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            pair_reg      <= pair_next;
            k_reg         <= k_next;
            owr_ptr_reg   <= owr_ptr_reg ^ emit;
            ord_ptr_reg   <= ord_ptr_reg ^ do_pop;
            ocnt_reg      <= ocnt_reg + {1'b0, emit} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
            ofifo_reg[owr_ptr_reg] <= trip;
    end

endmodule

### rtl/truss_element_stiffness_triplets_core.sv
// Top level of the truss element stiffness triplet core: configuration registers,
// front end, element queue and back end. Depends on trst_pkg and the trst_* modules.
//
//  channel  | handshake            | word
//  ---------+----------------------+-------------------------------------------
//  input    | push / full          | item   : nodes and end coordinates
//  result   | empty / pop          | result : row, column, value, last
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data (32 bits)
//
// An element enters each cycle while the element queue has room; the front forms cosines,
// products and entry magnitudes. The back emits one triplet per cycle while its result
// queue has room, through its single result port: 4 x (nonzero entries) triplets per
// element, up to 36. Elements with all entries zero or an out-of-range node emit nothing.
// Reset sets both registers to 1.0 and empties the queues. cfg_ready is always high.
module truss_element_stiffness_triplets_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  trst_pkg::item_t            item,
    output logic                       empty,
    input  logic                       pop,
    output trst_pkg::result_t          result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  trst_pkg::cfg_index_t       cfg_index,
    input  logic [trst_pkg::CFG_W-1:0] cfg_data
);
    import trst_pkg::*;

    logic [CFG_W-1:0] axial_reg, inv_len_reg;
    logic             q_push, q_ready, q_valid, q_pop;
    elem_t            q_wr_word, q_rd_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axial_reg   <= CFG_W'(65536);
            inv_len_reg <= CFG_W'(65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_AXIAL_STIFFNESS: axial_reg   <= cfg_data;
                CFG_INVERSE_LENGTH:  inv_len_reg <= cfg_data;
            endcase
        end
    end

    trst_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .item            (item),
        .axial_stiffness (axial_reg),
        .inverse_length  (inv_len_reg),
        .q_push          (q_push),
        .q_word          (q_wr_word),
        .q_ready         (q_ready)
    );

    trst_elem_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (q_push),
        .wr_word   (q_wr_word),
        .not_full  (q_ready),
        .rd_en     (q_pop),
        .rd_word   (q_rd_word),
        .not_empty (q_valid)
    );

    trst_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_word  (q_rd_word),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

### rtl/trst_checker.sv
// Port-level checks for the truss stiffness triplet core, bound to the top level.
// Depends on trst_pkg and truss_element_stiffness_triplets_core_defines.svh.
`include "truss_element_stiffness_triplets_core_defines.svh"

module trst_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              empty,
    input logic              pop,
    input trst_pkg::result_t result,
    input logic              cfg_ready
);
    import trst_pkg::*;

    logic [VAL_W-MAG_W-1:0] value_top;

    // magnitudes stay within 34 bits, so the top bits are a pure sign extension
    assign value_top = result.stiffness_value[VAL_W-1:MAG_W];

    `TRST_ASSERT_HOLDS(a_cfg_always_ready, cfg_ready)
    `TRST_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(result))
    `TRST_ASSERT_IMPL(a_no_zero_word, !empty, result.stiffness_value != '0)
    `TRST_ASSERT_IMPL(a_value_extent, !empty, (value_top == '0) || (value_top == '1))

endmodule

bind truss_element_stiffness_triplets_core trst_checker u_trst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_ready (cfg_ready)
);
